/* rtl/symmetry_site_expander_dedup_core_macros.svh */
// ----------------------------------------------------------------------------
// Symmetry site expander - assertion macros
// Shared concurrent-assertion helpers for the site expander RTL.
// ----------------------------------------------------------------------------
`ifndef SYMMETRY_SITE_EXPANDER_DEDUP_CORE_MACROS_SVH
`define SYMMETRY_SITE_EXPANDER_DEDUP_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ssed_pkg.sv */
// ----------------------------------------------------------------------------
// Symmetry site expander - package
// Sizes, codes, FSM type and the operator row arithmetic.
// ----------------------------------------------------------------------------
package ssed_pkg;

    localparam int MAX_OPS    = 64;
    localparam int MAX_SITES  = 1024;
    localparam int FRAC_BITS  = 16;

    localparam int FUNC_W     = 2;
    localparam int ROT_W      = 18;
    localparam int COORD_W    = 16;
    localparam int TAG_W      = 16;
    localparam int OP_INDEX_W = 6;
    localparam int THR_W      = 34;

    localparam logic [THR_W-1:0] THR_RESET = 34'd4295;

    localparam int OPC_W  = $clog2(MAX_OPS + 1);
    localparam int OPA_W  = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam int SC_W   = $clog2(MAX_SITES + 1);
    localparam int SA_W   = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int SITE_W = 3 * FRAC_BITS;
    localparam int OP_W   = ROT_W + SITE_W;
    localparam int SQ_W   = 2 * FRAC_BITS;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;

    typedef logic [FRAC_BITS-1:0] frac_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_LOAD   = 2'd1,
        FUNC_EXPAND = 2'd2
    } func_t;

    localparam logic [1:0] COEF_PLUS  = 2'd1;
    localparam logic [1:0] COEF_MINUS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP_RD,
        ST_OP_WAIT,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic busy;
        logic hit;
    } dist_status_t;

    function automatic frac_t coef_term(input logic [1:0] code, input frac_t v);
        frac_t res;
        case (code)
            COEF_PLUS:  res = v;
            COEF_MINUS: res = frac_t'(0) - v;
            default:    res = '0;
        endcase
        return res;
    endfunction

    // One output row: translation plus signed unit terms, wrapped mod one.
    function automatic frac_t xform_row(input logic [5:0] codes, input frac_t t,
                                        input frac_t p0, input frac_t p1,
                                        input frac_t p2);
        frac_t res;
        res = t + coef_term(codes[1:0], p0) + coef_term(codes[3:2], p1)
                + coef_term(codes[5:4], p2);
        return res;
    endfunction

endpackage

/* rtl/ssed_item_if.sv */
// ----------------------------------------------------------------------------
// Symmetry site expander - input item channel
// Valid/ready channel carrying one command or atom item.
// ----------------------------------------------------------------------------
interface ssed_item_if;
    import ssed_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [ROT_W-1:0]     rotation_code;
    logic [COORD_W-1:0]   coord_x;
    logic [COORD_W-1:0]   coord_y;
    logic [COORD_W-1:0]   coord_z;
    logic [TAG_W-1:0]     atom_tag;

    modport source (
        output valid, func, rotation_code, coord_x, coord_y, coord_z, atom_tag,
        input  ready
    );

    modport sink (
        input  valid, func, rotation_code, coord_x, coord_y, coord_z, atom_tag,
        output ready
    );
endinterface

/* rtl/ssed_result_if.sv */
// ----------------------------------------------------------------------------
// Symmetry site expander - result channel
// Valid/ready channel carrying one expanded site result.
// ----------------------------------------------------------------------------
interface ssed_result_if;
    import ssed_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [TAG_W-1:0]      out_tag;
    logic [COORD_W-1:0]    new_x;
    logic [COORD_W-1:0]    new_y;
    logic [COORD_W-1:0]    new_z;
    logic [OP_INDEX_W-1:0] op_index;
    logic                  is_new;
    logic                  dropped;
    logic                  last;

    modport source (
        output valid, out_tag, new_x, new_y, new_z, op_index, is_new, dropped, last,
        input  ready
    );

    modport sink (
        input  valid, out_tag, new_x, new_y, new_z, op_index, is_new, dropped, last,
        output ready
    );
endinterface

/* rtl/ssed_ram.sv */
// ----------------------------------------------------------------------------
// Symmetry site expander - generic RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module ssed_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/ssed_dist.sv */
// ----------------------------------------------------------------------------
// Symmetry site expander - distance unit
// Three-stage squared-distance pipeline shared by every site compare:
// absolute difference, square, sum and threshold compare.
// ----------------------------------------------------------------------------
module ssed_dist (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid,
    input  logic [ssed_pkg::SITE_W-1:0] site,
    input  logic [ssed_pkg::SITE_W-1:0] q,
    input  logic [ssed_pkg::THR_W-1:0]  thr,
    output ssed_pkg::dist_status_t      status
);
    import ssed_pkg::*;

    logic              v1_reg, v2_reg, v3_reg;
    frac_t             diff_reg [3];
    frac_t             diff_next [3];
    logic [SQ_W-1:0]   sq_reg [3];
    logic [SUM_W-1:0]  sum;
    logic              lt_reg, lt_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (site[i*FRAC_BITS +: FRAC_BITS] >= q[i*FRAC_BITS +: FRAC_BITS])
            begin
                diff_next[i] = site[i*FRAC_BITS +: FRAC_BITS] - q[i*FRAC_BITS +: FRAC_BITS];
            end
            else
            begin
                diff_next[i] = q[i*FRAC_BITS +: FRAC_BITS] - site[i*FRAC_BITS +: FRAC_BITS];
            end
        end
        sum     = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        lt_next = CMP_W'(sum) < CMP_W'(thr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff_reg[i] <= diff_next[i];
            sq_reg[i]   <= SQ_W'(diff_reg[i]) * SQ_W'(diff_reg[i]);
        end
        lt_reg <= lt_next;
    end

    assign status.busy = v1_reg | v2_reg | v3_reg;
    assign status.hit  = v3_reg & lt_reg;

endmodule

/* rtl/symmetry_site_expander_dedup_core.sv */
// ----------------------------------------------------------------------------
// Symmetry site expander with duplicate removal - top level
// Keeps an operator table and a site store; expands each atom by every
// operator and appends sites not within threshold of a stored one until full.
// ----------------------------------------------------------------------------
// Clear and load items are done in the idle state. An expand item steps, per
// operator, through op read, op wait, a scan of the N stored sites from the
// site-store read port into the shared distance pipeline, and a decide state.
// Results leave through an output register; the next item is taken once the
// last result is registered. Reset zeroes both counts and loads threshold 4295;
// table and store contents are undefined and need no clearing pass.
`include "symmetry_site_expander_dedup_core_macros.svh"

module symmetry_site_expander_dedup_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [ssed_pkg::THR_W-1:0] cfg_wdata,
    ssed_item_if.sink                  item,
    ssed_result_if.source              result
);
    import ssed_pkg::*;

    state_t               state_reg, state_next;
    logic [THR_W-1:0]     thr_reg;
    logic [OPC_W-1:0]     op_count_reg, op_count_next;
    logic [SC_W-1:0]      site_count_reg, site_count_next;
    logic [SC_W-1:0]      scan_idx_reg, scan_idx_next;
    logic [OPA_W-1:0]     k_reg, k_next;
    logic                 dup_reg, dup_next;
    logic                 rd_valid_reg;
    logic                 out_valid_reg, out_valid_next;

    frac_t                px_reg, py_reg, pz_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [SITE_W-1:0]    q_reg, q_next;

    logic [TAG_W-1:0]      out_tag_reg;
    logic [COORD_W-1:0]    out_x_reg, out_y_reg, out_z_reg;
    logic [OP_INDEX_W-1:0] out_op_reg;
    logic                  out_new_reg, out_drop_reg, out_last_reg;

    logic                 item_xfer;
    logic                 q_load, out_load, last_op, store_full;

    logic                 op_we, op_re;
    logic [OP_W-1:0]      op_wdata, op_rdata;
    logic                 site_we, site_re;
    logic [SITE_W-1:0]    site_rdata;
    logic [ROT_W-1:0]     rot;
    dist_status_t         dist_status;

    assign item_xfer  = item.valid & item.ready;
    assign item.ready = (state_reg == ST_IDLE);
    assign last_op    = ((OPC_W'(k_reg) + OPC_W'(1)) == op_count_reg);
    assign store_full = (site_count_reg >= SC_W'(MAX_SITES));
    assign op_wdata   = {item.rotation_code, frac_t'(item.coord_z),
                         frac_t'(item.coord_y), frac_t'(item.coord_x)};
    assign rot        = op_rdata[SITE_W +: ROT_W];

    always_comb
    begin
        q_next[0*FRAC_BITS +: FRAC_BITS] = xform_row(rot[5:0],
            op_rdata[0*FRAC_BITS +: FRAC_BITS], px_reg, py_reg, pz_reg);
        q_next[1*FRAC_BITS +: FRAC_BITS] = xform_row(rot[11:6],
            op_rdata[1*FRAC_BITS +: FRAC_BITS], px_reg, py_reg, pz_reg);
        q_next[2*FRAC_BITS +: FRAC_BITS] = xform_row(rot[17:12],
            op_rdata[2*FRAC_BITS +: FRAC_BITS], px_reg, py_reg, pz_reg);
    end

    ssed_ram #(.WIDTH(OP_W), .DEPTH(MAX_OPS)) u_op_ram (
        .clk   (clk),
        .we    (op_we),
        .waddr (op_count_reg[OPA_W-1:0]),
        .wdata (op_wdata),
        .re    (op_re),
        .raddr (k_reg),
        .rdata (op_rdata)
    );

    ssed_ram #(.WIDTH(SITE_W), .DEPTH(MAX_SITES)) u_site_ram (
        .clk   (clk),
        .we    (site_we),
        .waddr (site_count_reg[SA_W-1:0]),
        .wdata (q_reg),
        .re    (site_re),
        .raddr (scan_idx_reg[SA_W-1:0]),
        .rdata (site_rdata)
    );

    ssed_dist u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (rd_valid_reg),
        .site   (site_rdata),
        .q      (q_reg),
        .thr    (thr_reg),
        .status (dist_status)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_count_next   = op_count_reg;
        site_count_next = site_count_reg;
        scan_idx_next   = scan_idx_reg;
        k_next          = k_reg;
        dup_next        = dup_reg;
        op_we           = 1'b0;
        op_re           = 1'b0;
        site_we         = 1'b0;
        site_re         = 1'b0;
        q_load          = 1'b0;
        out_load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    case (item.func)
                        FUNC_CLEAR:
                        begin
                            op_count_next   = '0;
                            site_count_next = '0;
                        end
                        FUNC_LOAD:
                        begin
                            // drop loads once the table is full
                            if (op_count_reg < OPC_W'(MAX_OPS))
                            begin
                                op_we         = 1'b1;
                                op_count_next = op_count_reg + OPC_W'(1);
                            end
                        end
                        FUNC_EXPAND:
                        begin
                            if (op_count_reg != '0)
                            begin
                                k_next     = '0;
                                state_next = ST_OP_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_OP_RD:
            begin
                op_re      = 1'b1;
                state_next = ST_OP_WAIT;
            end
            ST_OP_WAIT:
            begin
                q_load        = 1'b1;
                dup_next      = 1'b0;
                scan_idx_next = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_idx_reg < site_count_reg)
                begin
                    site_re       = 1'b1;
                    scan_idx_next = scan_idx_reg + SC_W'(1);
                end
                else if (!rd_valid_reg && !dist_status.busy)
                begin
                    state_next = ST_DECIDE;
                end
                if (dist_status.hit)
                begin
                    dup_next = 1'b1;
                end
            end
            ST_DECIDE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_load = 1'b1;
                    if (!dup_reg && !store_full)
                    begin
                        site_we         = 1'b1;
                        site_count_next = site_count_reg + SC_W'(1);
                    end
                    if (last_op)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + OPA_W'(1);
                        state_next = ST_OP_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            thr_reg        <= THR_RESET;
            op_count_reg   <= '0;
            site_count_reg <= '0;
            scan_idx_reg   <= '0;
            k_reg          <= '0;
            dup_reg        <= 1'b0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_count_reg   <= op_count_next;
            site_count_reg <= site_count_next;
            scan_idx_reg   <= scan_idx_next;
            k_reg          <= k_next;
            dup_reg        <= dup_next;
            rd_valid_reg   <= site_re;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            px_reg  <= frac_t'(item.coord_x);
            py_reg  <= frac_t'(item.coord_y);
            pz_reg  <= frac_t'(item.coord_z);
            tag_reg <= item.atom_tag;
        end
        if (q_load)
        begin
            q_reg <= q_next;
        end
        if (out_load)
        begin
            out_tag_reg  <= tag_reg;
            out_x_reg    <= COORD_W'(q_reg[0*FRAC_BITS +: FRAC_BITS]);
            out_y_reg    <= COORD_W'(q_reg[1*FRAC_BITS +: FRAC_BITS]);
            out_z_reg    <= COORD_W'(q_reg[2*FRAC_BITS +: FRAC_BITS]);
            out_op_reg   <= OP_INDEX_W'(k_reg);
            out_new_reg  <= !dup_reg && !store_full;
            out_drop_reg <= !dup_reg && store_full;
            out_last_reg <= last_op;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.out_tag  = out_tag_reg;
    assign result.new_x    = out_x_reg;
    assign result.new_y    = out_y_reg;
    assign result.new_z    = out_z_reg;
    assign result.op_index = out_op_reg;
    assign result.is_new   = out_new_reg;
    assign result.dropped  = out_drop_reg;
    assign result.last     = out_last_reg;

    `SSED_ASSERT_NOW(a_counts_in_range, clk, rst_n, 1'b1,
        (site_count_reg <= SC_W'(MAX_SITES)) && (op_count_reg <= OPC_W'(MAX_OPS)),
        "table or store count beyond capacity")
    `SSED_ASSERT_NOW(a_new_not_dropped, clk, rst_n, result.valid,
        !(result.is_new && result.dropped), "result flagged both new and dropped")
    `SSED_ASSERT_NEXT(a_store_grows, clk, rst_n, site_we,
        site_count_reg == $past(site_count_reg) + SC_W'(1), "store append lost")
    `SSED_ASSERT_NOW(a_drained_decide, clk, rst_n, state_reg == ST_DECIDE,
        !dist_status.busy && !rd_valid_reg, "decision taken with compares in flight")

endmodule
